>>> hw/rtl/trial_division_prime_test_defines.svh
// assertion macros shared by the prime test rtl
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tdpt_pkg.sv
// shared widths and control and status types for the trial division prime test
package tdpt_pkg;

  localparam int VALUE_BITS = 16;
  localparam int DIV_BITS   = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS    = VALUE_BITS + 1;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [DIV_BITS-1:0]   divisor_t;

  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } mod_sts_t;

endpackage

>>> hw/rtl/trial_division_prime_test.sv
// top level: trial division primality test over a serial remainder unit
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_candidate        | into block
//  out     | out_valid, out_ready, out_tested_value, | out of block
//          | out_is_prime                            |
//
// one word at a time; per trial divisor: a check, 16 remainder bits through the serial unit,
// then its done strobe; the verdict leaves via the done state and the block returns to idle;
// the worst case between words is a 16-bit prime near the top of the range
// rst_n is synchronous and clears control state only
// in_ready is high whenever no candidate is in work, even with a word held on out;
// a finished verdict waits in its state until the output slot frees
`include "trial_division_prime_test_defines.svh"

module trial_division_prime_test (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tdpt_pkg::value_t in_candidate,
  output logic             out_valid,
  input  logic             out_ready,
  output tdpt_pkg::value_t out_tested_value,
  output logic             out_is_prime
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  localparam int SQ_PAD = tdpt_pkg::SQ_BITS - tdpt_pkg::DIV_BITS - 1;

  state_t                          st_r, st_nxt;
  tdpt_pkg::value_t                cand_r, cand_nxt;
  tdpt_pkg::divisor_t              j_r, j_nxt;
  logic [tdpt_pkg::SQ_BITS-1:0]    sq_r, sq_nxt;
  logic                            prime_r, prime_nxt;
  logic                            out_valid_r, out_valid_nxt;
  tdpt_pkg::value_t                out_val_r, out_val_nxt;
  logic                            out_prime_r, out_prime_nxt;
  tdpt_pkg::mod_ctl_t              mod_ctl;
  tdpt_pkg::mod_sts_t              mod_sts;
  logic                            in_acc;

  assign in_ready = (st_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    st_nxt        = st_r;
    cand_nxt      = cand_r;
    j_nxt         = j_r;
    sq_nxt        = sq_r;
    prime_nxt     = prime_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_prime_nxt = out_prime_r;
    mod_ctl.start = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          cand_nxt = in_candidate;
          j_nxt    = tdpt_pkg::DIV_BITS'(2);
          sq_nxt   = tdpt_pkg::SQ_BITS'(4);
          st_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cand_r < tdpt_pkg::VALUE_BITS'(2)) begin
          prime_nxt = 1'b0;
          st_nxt    = ST_DONE;
        end else if (sq_r > {1'b0, cand_r}) begin
          prime_nxt = 1'b1;
          st_nxt    = ST_DONE;
        end else begin
          mod_ctl.start = 1'b1;
          st_nxt        = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (mod_sts.done) begin
          if (mod_sts.rem_zero) begin
            prime_nxt = 1'b0;
            st_nxt    = ST_DONE;
          end else begin
            j_nxt  = j_r + 1'b1;
            sq_nxt = sq_r + {{SQ_PAD{1'b0}}, j_r, 1'b1};
            st_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = cand_r;
          out_prime_nxt = prime_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    j_r         <= j_nxt;
    sq_r        <= sq_nxt;
    prime_r     <= prime_nxt;
    out_val_r   <= out_val_nxt;
    out_prime_r <= out_prime_nxt;
  end

  tdpt_serial_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mod_ctl),
    .dividend (cand_r),
    .divisor  (j_r),
    .sts      (mod_sts)
  );

  assign out_valid        = out_valid_r;
  assign out_tested_value = out_val_r;
  assign out_is_prime     = out_prime_r;

  `TDPT_ASSERT_NEXT(a_acc_check, in_acc, st_r == ST_CHECK, "accepted word did not start a check")
  `TDPT_ASSERT_NOW(a_prime_ge2, st_r == ST_DONE && prime_r,
    cand_r >= tdpt_pkg::VALUE_BITS'(2), "value below two marked prime")
  `TDPT_ASSERT_NEXT(a_zero_rem, st_r == ST_DIVIDE && mod_sts.done && mod_sts.rem_zero,
    st_r == ST_DONE && !prime_r, "exact divisor not reported composite")
  `TDPT_ASSERT_NOW(a_square, st_r == ST_CHECK,
    sq_r == tdpt_pkg::SQ_BITS'(j_r) * tdpt_pkg::SQ_BITS'(j_r), "square tracker out of step")
  `TDPT_ASSERT_NOW(a_mod_idle, st_r == ST_CHECK, !mod_sts.busy, "divider busy at a check")

endmodule

>>> hw/rtl/tdpt_serial_mod.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
`include "trial_division_prime_test_defines.svh"

module tdpt_serial_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  tdpt_pkg::mod_ctl_t ctl,
  input  tdpt_pkg::value_t   dividend,
  input  tdpt_pkg::divisor_t divisor,
  output tdpt_pkg::mod_sts_t sts
);

  localparam logic [tdpt_pkg::CNT_BITS-1:0] LAST_CNT =
    tdpt_pkg::CNT_BITS'(tdpt_pkg::VALUE_BITS - 1);

  tdpt_pkg::value_t                  shreg_r, shreg_nxt;
  tdpt_pkg::divisor_t                rem_r, rem_nxt;
  logic [tdpt_pkg::CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [tdpt_pkg::DIV_BITS+1:0]     trial;
  logic [tdpt_pkg::DIV_BITS+1:0]     diff;
  tdpt_pkg::divisor_t                step_rem;

  always_comb begin
    trial    = {1'b0, rem_r, shreg_r[tdpt_pkg::VALUE_BITS-1]};
    diff     = trial - {2'b00, divisor};
    step_rem = diff[tdpt_pkg::DIV_BITS+1] ? trial[tdpt_pkg::DIV_BITS-1:0]
                                          : diff[tdpt_pkg::DIV_BITS-1:0];
  end

  always_comb begin
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (ctl.start) begin
      shreg_nxt = dividend;
      rem_nxt   = '0;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shreg_nxt = {shreg_r[tdpt_pkg::VALUE_BITS-2:0], 1'b0};
      rem_nxt   = step_rem;
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.rem_zero = (rem_r == '0);

  `TDPT_ASSERT_NEXT(a_start_busy, ctl.start, busy_r && cnt_r == '0, "start did not arm the unit")
  `TDPT_ASSERT_NOW(a_rem_bound, done_r, rem_r < divisor, "remainder not below divisor")
  `TDPT_ASSERT_NOW(a_done_idle, done_r, !busy_r, "done while still shifting")

endmodule

>>> tb/prime_verdict_checker.sv
// checker for the trial division prime test: predicts each verdict and compares results
module prime_verdict_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  tdpt_pkg::value_t in_candidate,
  input  logic             out_valid,
  input  logic             out_ready,
  input  tdpt_pkg::value_t out_tested_value,
  input  logic             out_is_prime,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tdpt_pkg::value_t tested_value;
    logic             is_prime;
  } verdict_t;

  verdict_t pending_verdicts[$];
  int       error_total = 0;

  function automatic logic trial_division_verdict(input tdpt_pkg::value_t candidate);
    int unsigned n;
    int unsigned divisor;
    n = int'(candidate);
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    for (divisor = 2; divisor * divisor <= n; divisor++) begin
      if (n % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t predicted;
    verdict_t oldest;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted.tested_value = in_candidate;
        predicted.is_prime     = trial_division_verdict(in_candidate);
        pending_verdicts.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected word, tested_value %0d is_prime %0b", $time,
                   out_tested_value, out_is_prime);
          error_total++;
        end else begin
          oldest = pending_verdicts.pop_front();
          if (out_tested_value !== oldest.tested_value) begin
            $display("%0t: tested_value expected %0d actual %0d", $time,
                     oldest.tested_value, out_tested_value);
            error_total++;
          end
          if (out_is_prime !== oldest.is_prime) begin
            $display("%0t: is_prime of %0d expected %0b actual %0b", $time,
                     oldest.tested_value, oldest.is_prime, out_is_prime);
            error_total++;
          end
        end
      end
    end
    mismatches  <= error_total;
    outstanding <= pending_verdicts.size();
  end

endmodule

>>> tb/testbench.sv
// testbench top for the trial division prime test: stimulus, watchdog and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 50000;
  localparam int HOLD_CYCLES = 600;

  localparam tdpt_pkg::value_t CORNER_VALUES [0:22] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd9, 16'd25,
    16'd49, 16'd169, 16'd255, 16'd256, 16'd257, 16'd32767, 16'd32768,
    16'h5555, 16'haaaa, 16'd63001, 16'd65025, 16'd65521, 16'd65535
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  tdpt_pkg::value_t in_candidate = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  tdpt_pkg::value_t out_tested_value;
  logic             out_is_prime;

  int mismatches;
  int outstanding;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  trial_division_prime_test dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tested_value (out_tested_value),
    .out_is_prime     (out_is_prime)
  );

  prime_verdict_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tested_value (out_tested_value),
    .out_is_prime     (out_is_prime),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // receiver: random back-pressure, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_ready    <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic tdpt_pkg::value_t pick_candidate();
    int unsigned root;
    case ($urandom_range(3))
      0: return tdpt_pkg::value_t'($urandom_range(255));
      1: return tdpt_pkg::value_t'($urandom);
      2: return tdpt_pkg::value_t'($urandom_range(65535, 60000));
      default: begin
        root = $urandom_range(255, 2);
        return tdpt_pkg::value_t'(root * root);
      end
    endcase
  endfunction

  // leaves in_valid high after acceptance so back-to-back words need no re-raise
  task automatic send_word(input tdpt_pkg::value_t candidate);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_candidate <= candidate;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 19;
    out_idle_pct <= 69;
    foreach (CORNER_VALUES[i]) send_word(CORNER_VALUES[i]);
    repeat (40) send_word(pick_candidate());
    drain_results();

    in_idle_pct = 69;
    out_idle_pct <= 19;
    repeat (40) send_word(pick_candidate());
    drain_results();

    in_idle_pct = 0;
    out_idle_pct <= 0;
    hold_requests <= hold_requests + 1;
    repeat (12) send_word(tdpt_pkg::value_t'($urandom_range(255)));
    repeat (30) send_word(pick_candidate());
    drain_results();

    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
